// ===== hw/rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants for the text console character writer: field widths,
// operation codes, character codes and default screen geometry.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  // Port field widths
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

endpackage

// ===== hw/rtl/tccw_addr_unit.sv =====
// ----------------------------------------------------------------------------
// tccw_addr_unit
// Cell address unit: rotates a screen row by the top-row offset and forms
// physical_row * SCREEN_COLS + col.
// ----------------------------------------------------------------------------
module tccw_addr_unit #(
  parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic [$clog2(SCREEN_ROWS)-1:0]             row,
  input  logic [$clog2(SCREEN_COLS)-1:0]             col,
  input  logic [$clog2(SCREEN_ROWS)-1:0]             top,
  output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0] addr
);
  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS);

  localparam logic [RW:0]   ROWS_X = (RW+1)'(SCREEN_ROWS);
  localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);

  logic [RW:0]   row_sum;
  logic [RW-1:0] prow;

  // Row rotation: both operands are below SCREEN_ROWS, so one subtract wraps
  assign row_sum = {1'b0, row} + {1'b0, top};

  always_comb begin
    if (row_sum >= ROWS_X) begin
      prow = RW'(row_sum - ROWS_X);
    end else begin
      prow = RW'(row_sum);
    end
  end

  // Constant-width multiply and column add
  assign addr = AW'(AW'(prow) * COLS_A) + AW'(col);

endmodule

// ===== hw/rtl/tccw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Single-port cell memory with registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
  parameter int DEPTH = tccw_pkg::DEF_SCREEN_COLS * tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic [tccw_pkg::CELL_W-1:0] wr_data,
  output logic [tccw_pkg::CELL_W-1:0] rd_data
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text-mode console engine: character grid with cursor, wrap, scroll by
// top-row rotation, clear and single-cell read.
// ----------------------------------------------------------------------------
// Usage: after reset the block runs a clearing pass (busy high) that writes
// every cell of the grid with blanks of attribute 0x07. Items
// are taken when start is high and busy is low; exactly one result follows per
// item, shown for a single cycle with out_valid, and must be captured then.
// A put, newline, read or unused op goes from acceptance through the address
// calculation and execute states to the result state. A put that scrolls
// runs address calculation and execute again and then blanks the new bottom
// row, and a clear blanks the whole grid. The single-port cell memory
// writes one cell per cycle while a row or the whole grid is blanked, and
// each access uses an address registered from the address unit.
// cfg_wr_data sets the attribute used for characters and blanks.
// ----------------------------------------------------------------------------
module text_console_char_writer_top #(
  parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            start,
  output logic                            busy,
  input  logic [tccw_pkg::OP_W-1:0]       in_op,
  input  logic [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tccw_pkg::ROW_PORT_W-1:0] in_cell_row,
  input  logic [tccw_pkg::COL_PORT_W-1:0] in_cell_col,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_wr_data,
  // result transaction
  output logic                            out_valid,
  output logic [tccw_pkg::CELL_W-1:0]     out_cell_value,
  output logic [tccw_pkg::ROW_PORT_W-1:0] out_cursor_row,
  output logic [tccw_pkg::COL_PORT_W-1:0] out_cursor_col,
  output logic                            out_did_scroll
);
  import tccw_pkg::*;

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(SCREEN_COLS - 1);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CALC  = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_SWEEP = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Control registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic [CELL_W-1:0]  fill_r, fill_nxt;
  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      top_r, top_nxt;
  logic               scroll_pend_r, scroll_pend_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic [ATTR_W-1:0]  attr_r;

  // Transaction payload registers
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic [ROW_PORT_W-1:0] rrow_r, rrow_nxt;
  logic [COL_PORT_W-1:0] rcol_r, rcol_nxt;
  logic                  rd_ok_r, rd_ok_nxt;

  logic              accept;
  logic [RW-1:0]     row_sel;
  logic [CW-1:0]     col_sel;
  logic [AW-1:0]     unit_addr;
  logic              ram_we;
  logic              ram_re;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;
  logic              is_put;
  logic              is_nl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign is_put = (op_r == OP_PUT);
  assign is_nl  = (char_r == NEWLINE_CODE);

  // Operand select for the address unit
  always_comb begin
    if (scroll_pend_r) begin
      row_sel = LAST_ROW;
      col_sel = '0;
    end else if (op_r == OP_READ) begin
      row_sel = rd_ok_r ? RW'(rrow_r) : '0;
      col_sel = rd_ok_r ? CW'(rcol_r) : '0;
    end else begin
      row_sel = cur_row_r;
      col_sel = cur_col_r;
    end
  end

  tccw_addr_unit #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_addr_unit (
    .row  (row_sel),
    .col  (col_sel),
    .top  (top_r),
    .addr (unit_addr)
  );

  // Memory access: every access uses the registered address
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = {attr_r, char_r};
    if ((state_r == ST_INIT) || (state_r == ST_SWEEP)) begin
      ram_we    = 1'b1;
      ram_wdata = fill_r;
    end else if (state_r == ST_EXEC && !scroll_pend_r) begin
      ram_we = is_put && !is_nl;
      ram_re = (op_r == OP_READ) && rd_ok_r;
    end
  end

  tccw_cell_ram #(
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .rd_en   (ram_re),
    .addr    (addr_r),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    end_nxt         = end_r;
    fill_nxt        = fill_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    top_nxt         = top_r;
    scroll_pend_nxt = scroll_pend_r;
    scrolled_nxt    = scrolled_r;
    op_nxt          = op_r;
    char_nxt        = char_r;
    rrow_nxt        = rrow_r;
    rcol_nxt        = rcol_r;
    rd_ok_nxt       = rd_ok_r;

    unique case (state_r)
      ST_INIT: begin
        addr_nxt = addr_r + AW'(1);
        if (addr_r == end_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_nxt          = in_op;
          char_nxt        = in_char_code;
          rrow_nxt        = in_cell_row;
          rcol_nxt        = in_cell_col;
          rd_ok_nxt       = (int'(in_cell_row) < SCREEN_ROWS) &&
                            (int'(in_cell_col) < SCREEN_COLS);
          scroll_pend_nxt = 1'b0;
          scrolled_nxt    = 1'b0;
          if (in_op == OP_CLEAR) begin
            // whole-grid blank, cursor home, rotation undone
            addr_nxt    = '0;
            end_nxt     = LAST_CELL;
            fill_nxt    = {attr_r, SPACE_CODE};
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            top_nxt     = '0;
            state_nxt   = ST_SWEEP;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end

      ST_CALC: begin
        addr_nxt  = unit_addr;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        if (scroll_pend_r) begin
          // blank the new bottom row
          scroll_pend_nxt = 1'b0;
          end_nxt         = addr_r + ROW_SPAN;
          fill_nxt        = {attr_r, SPACE_CODE};
          state_nxt       = ST_SWEEP;
        end else if (is_put) begin
          state_nxt = ST_DONE;
          if (is_nl || (cur_col_r == LAST_COL)) begin
            cur_col_nxt = '0;
            if (cur_row_r == LAST_ROW) begin
              top_nxt         = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
              scroll_pend_nxt = 1'b1;
              scrolled_nxt    = 1'b1;
              state_nxt       = ST_CALC;
            end else begin
              cur_row_nxt = cur_row_r + RW'(1);
            end
          end else begin
            cur_col_nxt = cur_col_r + CW'(1);
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SWEEP: begin
        addr_nxt = addr_r + AW'(1);
        if (addr_r == end_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      addr_r        <= '0;
      end_r         <= LAST_CELL;
      fill_r        <= RESET_BLANK;
      cur_row_r     <= '0;
      cur_col_r     <= '0;
      top_r         <= '0;
      scroll_pend_r <= 1'b0;
      scrolled_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      addr_r        <= addr_nxt;
      end_r         <= end_nxt;
      fill_r        <= fill_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      top_r         <= top_nxt;
      scroll_pend_r <= scroll_pend_nxt;
      scrolled_r    <= scrolled_nxt;
    end
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  // Transaction payload
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    char_r  <= char_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  // Result
  assign out_valid      = (state_r == ST_DONE);
  assign out_cell_value = ((op_r == OP_READ) && rd_ok_r) ? ram_rdata : '0;
  assign out_cursor_row = ROW_PORT_W'(cur_row_r);
  assign out_cursor_col = COL_PORT_W'(cur_col_r);
  assign out_did_scroll = scrolled_r;

`ifndef SYNTHESIS
  // result strobe is a single-cycle pulse
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // a scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |-> (cur_row_r == LAST_ROW))
    else $error("scroll result with cursor off the bottom row");

  // a clear homes the cursor and undoes the rotation
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (op_r == OP_CLEAR)) |->
      (cur_row_r == '0 && cur_col_r == '0 && top_r == '0 && !out_did_scroll))
    else $error("clear result with cursor not home");

  // cursor column stays inside the grid
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(cur_col_r) < SCREEN_COLS))
    else $error("cursor column beyond last column");
`endif

endmodule
